>>> sv/mic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Magnetometer calibration package
// Shared widths, register indexes, reset values and pipeline control types.
// ----------------------------------------------------------------------------
package mic_pkg;

  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 16;
  localparam int RECIP_W = 24;
  localparam int BIAS_W  = 22;
  localparam int COEF_W  = 16;
  localparam int ROW_W   = 3 * COEF_W;
  localparam int SPROD_W = CNT_W + RECIP_W + 1;
  localparam int SCALE_SHIFT = 16;
  localparam int SCALED_W = SPROD_W - SCALE_SHIFT;
  localparam int VEC_W   = SCALED_W + 1;
  localparam int PROD_W  = COEF_W + VEC_W;
  localparam int ACC_W   = PROD_W + 4;
  localparam int ACC_SHIFT = 12;
  localparam int RES_W   = ACC_W - ACC_SHIFT;
  localparam int OUT_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ROW_W;

  localparam logic [CFG_IDX_W-1:0] REG_RECIP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_ZERO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_ONE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_TWO = 3'd6;

  localparam logic [RECIP_W-1:0] RECIP_RESET = 24'd2452;
  localparam logic signed [BIAS_W-1:0] BIAS_X_RESET = 22'sd134198;
  localparam logic signed [BIAS_W-1:0] BIAS_Y_RESET = 22'sd858167;
  localparam logic signed [BIAS_W-1:0] BIAS_Z_RESET = -22'sd358972;
  localparam logic [ROW_W-1:0] ROW_ZERO_RESET = 48'd280981066226717;
  localparam logic [ROW_W-1:0] ROW_ONE_RESET = 48'd281191983218721;
  localparam logic [ROW_W-1:0] ROW_TWO_RESET = 48'd31348987002806;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [OUT_W-1:0] result_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage
`default_nettype wire

>>> sv/magnetometer_iron_calibration_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Magnetometer hard- and soft-iron calibration core
// Turns one raw six-byte sample into three calibrated Q.8 field axes.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one sample word of six raw bytes, the
// output channel one word of three calibrated axes and a saturation flag.
// Both use valid and ready. The configuration channel writes one register
// per word by index and is always ready; writes must be made while the core
// is idle, which the core itself does not enforce.
// The datapath is a four-stage pipeline: three scaling lanes, then three
// soft-iron row lanes, then a merge stage that sums, rounds and saturates.
// Output valid rises once the accepted word has passed the s1, s2, s3 and s4
// registers, and one word is accepted every cycle unless a stalled output has
// filled all stages. Each stage holds its word while the next stage is full
// and held, so a stalled receiver fills the empty stages before the input is
// held off. Reset empties the pipeline and loads the default sensitivity,
// biases and matrix.
// ----------------------------------------------------------------------------
module magnetometer_iron_calibration_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mic_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mic_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [mic_pkg::BYTE_W-1:0]         x_low,
  input  wire logic [mic_pkg::BYTE_W-1:0]         x_high,
  input  wire logic [mic_pkg::BYTE_W-1:0]         y_low,
  input  wire logic [mic_pkg::BYTE_W-1:0]         y_high,
  input  wire logic [mic_pkg::BYTE_W-1:0]         z_low,
  input  wire logic [mic_pkg::BYTE_W-1:0]         z_high,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [mic_pkg::OUT_W-1:0]        calibrated_x,
  output logic signed [mic_pkg::OUT_W-1:0]        calibrated_y,
  output logic signed [mic_pkg::OUT_W-1:0]        calibrated_z,
  output logic                                    saturated_flag
);

  logic [mic_pkg::RECIP_W-1:0]       recip;
  logic signed [mic_pkg::BIAS_W-1:0] bias [3];
  logic [mic_pkg::ROW_W-1:0]         row [3];

  logic [3:0]         vld;
  mic_pkg::stage_en_t en;

  logic [mic_pkg::BYTE_W-1:0] raw_low [3];
  logic [mic_pkg::BYTE_W-1:0] raw_high [3];
  mic_pkg::vec_t              vec [3];
  mic_pkg::prod_t             prod [3][3];
  mic_pkg::result_t           result [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      recip   <= mic_pkg::RECIP_RESET;
      bias[0] <= mic_pkg::BIAS_X_RESET;
      bias[1] <= mic_pkg::BIAS_Y_RESET;
      bias[2] <= mic_pkg::BIAS_Z_RESET;
      row[0]  <= mic_pkg::ROW_ZERO_RESET;
      row[1]  <= mic_pkg::ROW_ONE_RESET;
      row[2]  <= mic_pkg::ROW_TWO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mic_pkg::REG_RECIP:    recip   <= cfg_data[mic_pkg::RECIP_W-1:0];
        mic_pkg::REG_BIAS_X:   bias[0] <= $signed(cfg_data[mic_pkg::BIAS_W-1:0]);
        mic_pkg::REG_BIAS_Y:   bias[1] <= $signed(cfg_data[mic_pkg::BIAS_W-1:0]);
        mic_pkg::REG_BIAS_Z:   bias[2] <= $signed(cfg_data[mic_pkg::BIAS_W-1:0]);
        mic_pkg::REG_ROW_ZERO: row[0]  <= cfg_data;
        mic_pkg::REG_ROW_ONE:  row[1]  <= cfg_data;
        mic_pkg::REG_ROW_TWO:  row[2]  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    en.s4    = !vld[3] || out_ready;
    en.s3    = !vld[2] || en.s4;
    en.s2    = !vld[1] || en.s3;
    en.s1    = !vld[0] || en.s2;
    in_ready = en.s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en.s1) begin
        vld[0] <= in_valid;
      end
      if (en.s2) begin
        vld[1] <= vld[0];
      end
      if (en.s3) begin
        vld[2] <= vld[1];
      end
      if (en.s4) begin
        vld[3] <= vld[2];
      end
    end
  end

  assign raw_low[0]  = x_low;
  assign raw_high[0] = x_high;
  assign raw_low[1]  = y_low;
  assign raw_high[1] = y_high;
  assign raw_low[2]  = z_low;
  assign raw_high[2] = z_high;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    mic_scale_lane u_scale (
      .clk      (clk),
      .en       (en),
      .raw_low  (raw_low[i]),
      .raw_high (raw_high[i]),
      .recip    (recip),
      .bias     (bias[i]),
      .vec      (vec[i])
    );

    mic_row_lane u_row (
      .clk  (clk),
      .en   (en),
      .row  (row[i]),
      .vec  (vec),
      .prod (prod[i])
    );
  end

  mic_merge u_merge (
    .clk    (clk),
    .en     (en),
    .prod   (prod),
    .result (result),
    .sat    (saturated_flag)
  );

  assign out_valid    = vld[3];
  assign calibrated_x = result[0];
  assign calibrated_y = result[1];
  assign calibrated_z = result[2];

endmodule
`default_nettype wire

>>> sv/mic_scale_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Axis scaling lane
// Joins one byte pair, scales it to Q.8 with rounding and removes the bias.
// ----------------------------------------------------------------------------
module mic_scale_lane (
  input  wire logic                                    clk,
  input  wire mic_pkg::stage_en_t                      en,
  input  wire logic [mic_pkg::BYTE_W-1:0]              raw_low,
  input  wire logic [mic_pkg::BYTE_W-1:0]              raw_high,
  input  wire logic [mic_pkg::RECIP_W-1:0]             recip,
  input  wire logic signed [mic_pkg::BIAS_W-1:0]       bias,
  output mic_pkg::vec_t                                vec
);

  logic signed [mic_pkg::CNT_W-1:0]    cnt;
  logic signed [mic_pkg::RECIP_W:0]    recip_s;
  logic signed [mic_pkg::SPROD_W-1:0]  sprod;
  logic signed [mic_pkg::SPROD_W-1:0]  rounded;
  logic signed [mic_pkg::SCALED_W-1:0] scaled;

  assign cnt     = $signed({raw_high, raw_low});
  assign recip_s = $signed({1'b0, recip});

  always_ff @(posedge clk) begin
    if (en.s1) begin
      sprod <= mic_pkg::SPROD_W'(cnt) * mic_pkg::SPROD_W'(recip_s);
    end
  end

  assign rounded = sprod + mic_pkg::SPROD_W'(1 <<< (mic_pkg::SCALE_SHIFT - 1));
  assign scaled  = $signed(rounded[mic_pkg::SPROD_W-1:mic_pkg::SCALE_SHIFT]);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      vec <= mic_pkg::VEC_W'(scaled) - mic_pkg::VEC_W'(bias);
    end
  end

endmodule
`default_nettype wire

>>> sv/mic_row_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Soft-iron row lane
// Multiplies the corrected vector by the three coefficients of one row.
// ----------------------------------------------------------------------------
module mic_row_lane (
  input  wire logic                       clk,
  input  wire mic_pkg::stage_en_t         en,
  input  wire logic [mic_pkg::ROW_W-1:0]  row,
  input  wire mic_pkg::vec_t              vec [3],
  output mic_pkg::prod_t                  prod [3]
);

  logic signed [mic_pkg::COEF_W-1:0] coef [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      coef[j] = $signed(row[j*mic_pkg::COEF_W +: mic_pkg::COEF_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      for (int j = 0; j < 3; j++) begin
        prod[j] <= mic_pkg::PROD_W'(coef[j]) * mic_pkg::PROD_W'(vec[j]);
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/mic_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Row merge stage
// Sums the row products, rounds to Q.8, saturates and raises the clip flag.
// ----------------------------------------------------------------------------
module mic_merge (
  input  wire logic               clk,
  input  wire mic_pkg::stage_en_t en,
  input  wire mic_pkg::prod_t     prod [3][3],
  output mic_pkg::result_t        result [3],
  output logic                    sat
);

  localparam logic signed [mic_pkg::RES_W-1:0] RES_MAX =
    mic_pkg::RES_W'((64'sd1 <<< (mic_pkg::OUT_W - 1)) - 64'sd1);
  localparam logic signed [mic_pkg::RES_W-1:0] RES_MIN =
    mic_pkg::RES_W'(-(64'sd1 <<< (mic_pkg::OUT_W - 1)));

  logic signed [mic_pkg::ACC_W-1:0] acc [3];
  logic signed [mic_pkg::RES_W-1:0] res [3];
  mic_pkg::result_t                 clip [3];
  logic [2:0]                       hit;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = mic_pkg::ACC_W'(prod[i][0]) + mic_pkg::ACC_W'(prod[i][1])
             + mic_pkg::ACC_W'(prod[i][2])
             + mic_pkg::ACC_W'(1 <<< (mic_pkg::ACC_SHIFT - 1));
      res[i] = $signed(acc[i][mic_pkg::ACC_W-1:mic_pkg::ACC_SHIFT]);
      if (res[i] > RES_MAX) begin
        clip[i] = mic_pkg::OUT_W'(RES_MAX);
        hit[i]  = 1'b1;
      end else if (res[i] < RES_MIN) begin
        clip[i] = mic_pkg::OUT_W'(RES_MIN);
        hit[i]  = 1'b1;
      end else begin
        clip[i] = mic_pkg::OUT_W'(res[i]);
        hit[i]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      result <= clip;
      sat    <= |hit;
    end
  end

endmodule
`default_nettype wire

>>> sv/mic_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calibration core checker
// Port-level checks on reset, flow, latency and the saturation flag.
// ----------------------------------------------------------------------------
module mic_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [mic_pkg::OUT_W-1:0]   calibrated_x,
  input wire logic signed [mic_pkg::OUT_W-1:0]   calibrated_y,
  input wire logic signed [mic_pkg::OUT_W-1:0]   calibrated_z,
  input wire logic                               saturated_flag
);

  localparam logic signed [mic_pkg::OUT_W-1:0] OUT_MAX = 32'sh7FFFFFFF;
  localparam logic signed [mic_pkg::OUT_W-1:0] OUT_MIN = 32'sh80000000;

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output word present straight after reset.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input held off while the output stage is empty.");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready
    |=> out_valid)
    else $error("Word did not reach the output after four flowing cycles.");

  a_sat_clipped: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated_flag |->
      calibrated_x == OUT_MAX || calibrated_x == OUT_MIN ||
      calibrated_y == OUT_MAX || calibrated_y == OUT_MIN ||
      calibrated_z == OUT_MAX || calibrated_z == OUT_MIN)
    else $error("Saturation flag raised with no axis at a limit.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(calibrated_x))
    else $error("Stalled output word changed.");

endmodule

bind magnetometer_iron_calibration_core mic_checker u_mic_checker (.*);
`default_nettype wire
